[hdl/okrt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// okrt_pkg
// Shared types and constants for the ordered keyed record table: command and
// response transactions, stored record layout, operation and status codes.
// ----------------------------------------------------------------------------
package okrt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // Field widths fixed by the interface
    localparam int KIND_W   = 3;
    localparam int KEY_W    = 16;
    localparam int PAYA_W   = 32;
    localparam int PAYB_W   = 16;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_AUTO_KEY_BASE = 1'b0;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_KEY = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_POS = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [KEY_W-1:0]         key;
        logic signed [PAYA_W-1:0] pay_a;
        logic [PAYB_W-1:0]        pay_b;
        logic [POS_W-1:0]         position;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [KEY_W-1:0]         out_key;
        logic signed [PAYA_W-1:0] out_pay_a;
        logic [PAYB_W-1:0]        out_pay_b;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAYA_W-1:0] pay_a;
        logic [PAYB_W-1:0] pay_b;
    } rec_t;

    // Configuration write towards the sequencer
    typedef struct packed {
        logic             load;
        logic [KEY_W-1:0] base;
    } cfg_wr_t;

endpackage
`default_nettype wire

[hdl/okrt_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// okrt_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
module okrt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[hdl/okrt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// okrt_ctrl
// Operation sequencer: decodes a command, walks the record RAM for key search
// and delete shift, keeps the record count and the automatic key counter, and
// registers the response strobe.
// ----------------------------------------------------------------------------
module okrt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire okrt_pkg::cmd_t                cmd,
    input  wire okrt_pkg::cfg_wr_t             cfg,
    output logic                               busy,
    output logic                               done,
    output okrt_pkg::rsp_t                     rsp,
    output logic                               wr_en,
    output logic [okrt_pkg::IDX_W-1:0]         wr_addr,
    output okrt_pkg::rec_t                     wr_data,
    output logic [okrt_pkg::IDX_W-1:0]         rd_addr,
    input  wire okrt_pkg::rec_t                rd_data
);

    import okrt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_SHIFT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEY_W-1:0]   next_key_reg, next_key_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;
    cmd_t               cmd_reg;

    logic               accept;
    logic               full;
    logic               hit;
    logic               last_scan;
    logic               more_shift;
    logic [KEY_W-1:0]   key_inc;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   count_dec;

    assign accept     = start && (state_reg == ST_IDLE);
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit        = (rd_data.key == cmd_reg.key);
    assign last_scan  = ((SUM_W'(idx_reg) + SUM_W'(1)) >= SUM_W'(count_reg));
    assign more_shift = ((SUM_W'(idx_reg) + SUM_W'(2)) < SUM_W'(count_reg));
    assign key_inc    = next_key_reg + KEY_W'(1);
    assign count_inc  = count_reg + CNT_W'(1);
    assign count_dec  = count_reg - CNT_W'(1);

    // Next-state and RAM access logic
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        next_key_next = cfg.load ? cfg.base : next_key_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data       = '0;
        rd_addr       = idx_reg + IDX_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (cmd.kind == KIND_READ) ? IDX_W'(cmd.position) : '0;
                if (accept)
                begin
                    done_next = 1'b1;
                    rsp_next  = '0;
                    rsp_next.status = STAT_OK;
                    idx_next  = '0;
                    case (cmd.kind)
                        KIND_LOAD:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_data.key   = cmd.key;
                                wr_data.pay_a = cmd.pay_a;
                                wr_data.pay_b = cmd.pay_b;
                                count_next    = count_inc;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_data.key      = key_inc;
                                wr_data.pay_a    = cmd.pay_a;
                                wr_data.pay_b    = cmd.pay_b;
                                count_next       = count_inc;
                                next_key_next    = key_inc;
                                rsp_next.out_key = key_inc;
                            end
                        end
                        KIND_UPDATE:
                        begin
                            if ((cmd.key == '0) || (count_reg == '0))
                            begin
                                rsp_next.status = STAT_BAD_KEY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = STAT_EMPTY;
                            end
                            else if (cmd.key == '0)
                            begin
                                rsp_next.status = STAT_BAD_KEY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_READ:
                        begin
                            if (CMP_W'(cmd.position) >= CMP_W'(count_reg))
                            begin
                                rsp_next.status = STAT_BAD_POS;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            // unused kinds: no change, status ok
                        end
                    endcase
                    rsp_next.count = COUNT_W'(count_next);
                end
            end

            // RAM data for the requested position is now valid
            ST_READ:
            begin
                done_next          = 1'b1;
                rsp_next           = '0;
                rsp_next.status    = STAT_OK;
                rsp_next.out_key   = rd_data.key;
                rsp_next.out_pay_a = rd_data.pay_a;
                rsp_next.out_pay_b = rd_data.pay_b;
                rsp_next.count     = COUNT_W'(count_reg);
                state_next         = ST_IDLE;
            end

            // Key search: rd_data holds entry idx_reg, next entry requested
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg.kind == KIND_UPDATE)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = idx_reg;
                        wr_data.key     = rd_data.key;
                        wr_data.pay_a   = cmd_reg.pay_a;
                        wr_data.pay_b   = cmd_reg.pay_b;
                        done_next       = 1'b1;
                        rsp_next        = '0;
                        rsp_next.status = STAT_OK;
                        rsp_next.count  = COUNT_W'(count_reg);
                        state_next      = ST_IDLE;
                    end
                    else if (last_scan)
                    begin
                        count_next      = count_dec;
                        done_next       = 1'b1;
                        rsp_next        = '0;
                        rsp_next.status = STAT_OK;
                        rsp_next.count  = COUNT_W'(count_dec);
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (last_scan)
                begin
                    done_next       = 1'b1;
                    rsp_next        = '0;
                    rsp_next.status = STAT_BAD_KEY;
                    rsp_next.count  = COUNT_W'(count_reg);
                    state_next      = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Delete shift: copy entry idx_reg+1 down into idx_reg
            ST_SHIFT:
            begin
                rd_addr = idx_reg + IDX_W'(2);
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (more_shift)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                else
                begin
                    count_next      = count_dec;
                    done_next       = 1'b1;
                    rsp_next        = '0;
                    rsp_next.status = STAT_OK;
                    rsp_next.count  = COUNT_W'(count_dec);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            count_reg    <= '0;
            next_key_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            next_key_reg <= next_key_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers: latched command and response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

[hdl/ordered_keyed_record_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_keyed_record_table
// Insertion-ordered table of keyed records with load, add, update, delete and
// positional read; APB register for the automatic key base.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one response
// follows, shown for a single cycle with done high, and the receiver cannot
// hold it off. Load, add, refused commands and unused kinds respond in the
// cycle after acceptance; a read goes through the RAM read port and the read
// state first. Update and delete search the table one entry per cycle from
// the start (the single RAM read port sets this); a delete that finds its
// key then shifts the later entries down one per cycle. No clearing pass is
// needed after reset: the table is read only below the record count.
// Writing auto_key_base also reloads the key counter; write it only while idle.
// ----------------------------------------------------------------------------
module ordered_keyed_record_table (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire okrt_pkg::cmd_t                     cmd,
    output logic                                    busy,
    output logic                                    done,
    output okrt_pkg::rsp_t                          rsp,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [okrt_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [okrt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [okrt_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    import okrt_pkg::*;

    logic [KEY_W-1:0]  auto_key_base_reg;
    logic              apb_wr;
    cfg_wr_t           cfg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    rec_t              wr_data;
    logic [IDX_W-1:0]  rd_addr;
    rec_t              rd_data;

    // APB register
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign cfg.load = apb_wr && (paddr[2] == REG_AUTO_KEY_BASE);
    assign cfg.base = pwdata[KEY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_key_base_reg <= '0;
        end
        else if (cfg.load)
        begin
            auto_key_base_reg <= cfg.base;
        end
    end

    assign prdata = (paddr[2] == REG_AUTO_KEY_BASE)
                  ? APB_DATA_W'(auto_key_base_reg) : '0;

    // Sequencer
    okrt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .cfg     (cfg),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Record store
    okrt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(rec_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    // A response only follows an accepted command or a running operation
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("response without a command");

    // A multi-cycle operation always ends with its response
    a_end_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("operation ended without response");

    // Record count never exceeds the table depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.count <= COUNT_W'(TABLE_DEPTH)))
        else $error("record count beyond table depth");

    // A refused append leaves the count at full depth
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == STAT_FULL)) |-> (rsp.count == COUNT_W'(TABLE_DEPTH)))
        else $error("full status with spare room");
`endif

endmodule
`default_nettype wire

[verif/tb_ordered_keyed_record_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ordered_keyed_record_table
// Self-checking bench for the ordered keyed record table. A walked list of
// directed commands covers the bad-key, empty and bad-position statuses and
// field extremes. Random traffic follows, under several automatic key bases,
// with the table kept small. Responses are checked field by field against a
// shadow copy of the table kept in the bench, or against typed-in expects.
// ----------------------------------------------------------------------------
module tb_ordered_keyed_record_table;
    import okrt_pkg::*;

    // Spare operation codes that the block must ignore
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam logic [APB_ADDR_W-1:0] AUTO_KEY_BASE_ADDR = APB_ADDR_W'(4 * REG_AUTO_KEY_BASE);
    localparam logic [KEY_W-1:0]      DIRECTED_BASE      = 16'd100;
    localparam int SOFT_TABLE_LIMIT = 40;
    localparam int WATCHDOG_LIMIT   = 8 * TABLE_DEPTH + 1000;
    localparam int SETTLE_CYCLES    = 2 * TABLE_DEPTH + 16;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    cmd_t                  cmd;
    logic                  busy;
    logic                  done;
    rsp_t                  rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ordered_keyed_record_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the table contents and key counter
    logic [KEY_W-1:0]  shadow_key [TABLE_DEPTH];
    logic [PAYA_W-1:0] shadow_pa  [TABLE_DEPTH];
    logic [PAYB_W-1:0] shadow_pb  [TABLE_DEPTH];
    int                shadow_count;
    logic [KEY_W-1:0]  shadow_next_key;

    rsp_t pending_rsp_q [$];
    int   err_cnt;
    int   quiet_cycles = 0;

    typedef struct {
        cmd_t op;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one command to the shadow table and return its response
    function automatic rsp_t apply_table_op(cmd_t c);
        rsp_t r;
        int   hit;
        int   i;
        r   = '0;
        hit = -1;
        for (i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_key[i] == c.key)
                hit = i;
        end
        case (c.kind)
            KIND_LOAD, KIND_ADD:
            begin
                if (shadow_count >= TABLE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    if (c.kind == KIND_ADD)
                    begin
                        shadow_next_key = shadow_next_key + 1'b1;
                        r.out_key = shadow_next_key;
                        shadow_key[shadow_count] = shadow_next_key;
                    end
                    else
                        shadow_key[shadow_count] = c.key;
                    shadow_pa[shadow_count] = c.pay_a;
                    shadow_pb[shadow_count] = c.pay_b;
                    shadow_count++;
                end
            end
            KIND_UPDATE:
            begin
                if (c.key == '0 || hit < 0)
                    r.status = STAT_BAD_KEY;
                else
                begin
                    shadow_pa[hit] = c.pay_a;
                    shadow_pb[hit] = c.pay_b;
                end
            end
            KIND_DELETE:
            begin
                if (shadow_count == 0)
                    r.status = STAT_EMPTY;
                else if (c.key == '0 || hit < 0)
                    r.status = STAT_BAD_KEY;
                else
                begin
                    for (i = hit; i + 1 < shadow_count; i++)
                    begin
                        shadow_key[i] = shadow_key[i + 1];
                        shadow_pa[i]  = shadow_pa[i + 1];
                        shadow_pb[i]  = shadow_pb[i + 1];
                    end
                    shadow_count--;
                end
            end
            KIND_READ:
            begin
                if (int'(c.position) >= shadow_count)
                    r.status = STAT_BAD_POS;
                else
                begin
                    r.out_key   = shadow_key[c.position];
                    r.out_pay_a = shadow_pa[c.position];
                    r.out_pay_b = shadow_pb[c.position];
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // Keys: mostly ones present in the table, plus the extremes and noise
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll <= 5 && shadow_count > 0)
            return shadow_key[$urandom_range(0, shadow_count - 1)];
        else if (roll == 6)
            return '0;
        else if (roll == 7)
            return '1;
        else if (roll == 8)
            return KEY_W'($urandom_range(1, 16));
        return KEY_W'($urandom_range(0, 65535));
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   roll;
        c       = '0;
        roll    = $urandom_range(0, 99);
        c.key   = pick_key();
        c.pay_a = $urandom;
        c.pay_b = PAYB_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0)
            c.position = POS_W'($urandom_range(0, 1023));
        else
            c.position = POS_W'($urandom_range(0, shadow_count + 1));
        if (roll < 15)
            c.kind = KIND_LOAD;
        else if (roll < 30)
            c.kind = KIND_ADD;
        else if (roll < 50)
            c.kind = KIND_UPDATE;
        else if (roll < 72)
            c.kind = KIND_DELETE;
        else if (roll < 94)
            c.kind = KIND_READ;
        else
            c.kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        // keep the table short so searches stay cheap
        if (shadow_count >= SOFT_TABLE_LIMIT && (c.kind == KIND_LOAD || c.kind == KIND_ADD))
            c.kind = KIND_DELETE;
        return c;
    endfunction

    function automatic void add_row(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                    logic [PAYA_W-1:0] pa, logic [PAYB_W-1:0] pb,
                                    logic [POS_W-1:0] pos, bit typed,
                                    logic [STATUS_W-1:0] st, logic [KEY_W-1:0] okey,
                                    logic [PAYA_W-1:0] opa, logic [PAYB_W-1:0] opb,
                                    logic [COUNT_W-1:0] cnt);
        dir_row_t row;
        row.op.kind          = kind;
        row.op.key           = key;
        row.op.pay_a         = pa;
        row.op.pay_b         = pb;
        row.op.position      = pos;
        row.typed            = typed;
        row.want.status      = st;
        row.want.out_key     = okey;
        row.want.out_pay_a   = opa;
        row.want.out_pay_b   = opb;
        row.want.count       = cnt;
        dir_rows.push_back(row);
    endfunction

    // Directed list; expects typed in only where they are obvious
    function automatic void build_directed();
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd0,    1,
                STAT_BAD_POS, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_DELETE, 16'd5,    32'd0,        16'd0,      10'd0,    1,
                STAT_EMPTY, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_UPDATE, 16'd7,    32'd1,        16'd1,      10'd0,    1,
                STAT_BAD_KEY, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_LOAD,   16'd0,    32'h80000000, 16'hFFFF,   10'd0,    1,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd1);
        add_row(KIND_LOAD,   16'hFFFF, 32'h7FFFFFFF, 16'd0,      10'd0,    1,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd2);
        add_row(KIND_ADD,    16'd0,    32'hFFFFFFFF, 16'h1234,   10'd0,    1,
                STAT_OK, DIRECTED_BASE + 16'd1, 32'd0, 16'd0, 11'd3);
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd0,    1,
                STAT_OK, 16'd0, 32'h80000000, 16'hFFFF, 11'd3);
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd1,    1,
                STAT_OK, 16'hFFFF, 32'h7FFFFFFF, 16'd0, 11'd3);
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd1023, 1,
                STAT_BAD_POS, 16'd0, 32'd0, 16'd0, 11'd3);
        add_row(KIND_UPDATE, 16'd0,    32'd9,        16'd9,      10'd0,    1,
                STAT_BAD_KEY, 16'd0, 32'd0, 16'd0, 11'd3);
        add_row(KIND_DELETE, 16'd0,    32'd0,        16'd0,      10'd0,    1,
                STAT_BAD_KEY, 16'd0, 32'd0, 16'd0, 11'd3);
        add_row(KIND_UPDATE, 16'hFFFF, 32'd5,        16'd6,      10'd0,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_UPDATE, 16'd1234, 32'd5,        16'd6,      10'd0,    1,
                STAT_BAD_KEY, 16'd0, 32'd0, 16'd0, 11'd3);
        add_row(KIND_DELETE, 16'd999,  32'd0,        16'd0,      10'd0,    1,
                STAT_BAD_KEY, 16'd0, 32'd0, 16'd0, 11'd3);
        // duplicate of the automatic key; delete must take the first one
        add_row(KIND_LOAD,   DIRECTED_BASE + 16'd1, 32'h55, 16'h55, 10'd0, 0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_DELETE, DIRECTED_BASE + 16'd1, 32'd0,  16'd0,  10'd0, 0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd2,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_DELETE, 16'hFFFF, 32'd0,        16'd0,      10'd0,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_SPARE_FIRST, 16'd7, 32'd7,      16'd7,      10'd0,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_SPARE_MID,   16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 10'd1023, 0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_SPARE_LAST,  16'd1, 32'd1,      16'd1,      10'd1,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd0,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd1,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_ADD,    16'd0,    32'h0BADF00D, 16'hBEEF,   10'd0,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
        add_row(KIND_READ,   16'd0,    32'd0,        16'd0,      10'd2,    0,
                STAT_OK, 16'd0, 32'd0, 16'd0, 11'd0);
    endfunction

    // Issue one command and wait for it to be taken
    task automatic send(cmd_t c, bit typed, rsp_t want);
        rsp_t pred;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pred = apply_table_op(c);
        pending_rsp_q.push_back(typed ? want : pred);
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Hold off until every response is in and the block is quiet
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write followed by a read-back
    task automatic write_auto_key_base(logic [KEY_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AUTO_KEY_BASE_ADDR;
        pwdata  <= APB_DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_next_key = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(v))
        begin
            $error("auto_key_base: expected %0h, got %0h", v, prdata);
            err_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_ops(int n, bit gaps);
        int   burst_left;
        cmd_t c;
        burst_left = 0;
        repeat (n)
        begin
            if (gaps && burst_left == 0)
            begin
                idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 12);
            end
            if ($urandom_range(0, 24) == 0)
                drain();
            c = random_cmd();
            send(c, 1'b0, '0);
            if (burst_left > 0)
                burst_left--;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("response with no command outstanding");
                err_cnt++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                check_field("status",    32'(want.status),    32'(rsp.status));
                check_field("out_key",   32'(want.out_key),   32'(rsp.out_key));
                check_field("out_pay_a", want.out_pay_a,      rsp.out_pay_a);
                check_field("out_pay_b", 32'(want.out_pay_b), 32'(rsp.out_pay_b));
                check_field("count",     32'(want.count),     32'(rsp.count));
            end
        end
    end

    // Watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int   i;
        start        = 1'b0;
        cmd          = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        err_cnt      = 0;
        shadow_count    = 0;
        shadow_next_key = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk
        write_auto_key_base(DIRECTED_BASE);
        build_directed();
        for (i = 0; i < dir_rows.size(); i++)
        begin
            idle_cycles($urandom_range(0, 3));
            send(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
        end
        drain();

        // random traffic under several key bases; the second run has no gaps
        write_auto_key_base(16'hFFFE);
        random_ops(90, 1'b1);
        drain();
        write_auto_key_base(16'h0000);
        random_ops(90, 1'b0);
        drain();
        write_auto_key_base(KEY_W'($urandom_range(1, 65534)));
        random_ops(90, 1'b1);
        drain();

        // let any late response show up
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_rsp_q.size() != 0)
        begin
            $error("%0d responses never arrived", pending_rsp_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
